// ===== rtl/akc_pkg.sv =====
package akc_pkg;

  localparam int unsigned KeyMax   = 12;
  localparam int unsigned SlotW    = 5;
  localparam int unsigned PosW     = $clog2(KeyMax);
  localparam int unsigned KeyW     = SlotW * KeyMax;
  localparam int unsigned LenW     = 4;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned AddrW    = 4;
  localparam int unsigned DataW    = 64;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW    = $clog2(QueueDepth);
  localparam int unsigned QCntW    = $clog2(QueueDepth + 1);

  localparam logic [ByteW-1:0] CharA   = 8'h41;
  localparam logic [ByteW-1:0] CharZ   = 8'h5A;
  localparam logic [SlotW:0]   Modulus = 6'd26;

  // Register index, taken from address bit 3 (registers are 8 bytes apart).
  localparam logic RegKeyLetters = 1'b0;
  localparam logic RegKeyLength  = 1'b1;

  localparam logic [LenW-1:0] KeyLenReset = LenW'(1);

  // One classified request on its way from the front to the back.
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             is_letter;
    logic             start;
  } akc_item_t;

  typedef struct packed {
    logic [KeyW-1:0] key_letters;
    logic [LenW-1:0] key_length;
  } akc_cfg_t;

endpackage

// ===== rtl/akc_regs.sv =====
module akc_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [akc_pkg::AddrW-1:0] paddr,
  input  logic [akc_pkg::DataW-1:0] pwdata,
  output logic [akc_pkg::DataW-1:0] prdata,
  output logic                      pready,
  output akc_pkg::akc_cfg_t         cfg_o
);

  logic [akc_pkg::KeyW-1:0] key_letters_q, key_letters_d;
  logic [akc_pkg::LenW-1:0] key_length_q, key_length_d;
  logic                     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    key_letters_d = key_letters_q;
    key_length_d  = key_length_q;
    if (wr_en) begin
      case (paddr[3])
        akc_pkg::RegKeyLetters: key_letters_d = pwdata[akc_pkg::KeyW-1:0];
        akc_pkg::RegKeyLength:  key_length_d  = pwdata[akc_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3])
      akc_pkg::RegKeyLetters: prdata = akc_pkg::DataW'(key_letters_q);
      akc_pkg::RegKeyLength:  prdata = akc_pkg::DataW'(key_length_q);
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_letters_q <= '0;
      key_length_q  <= akc_pkg::KeyLenReset;
    end else begin
      key_letters_q <= key_letters_d;
      key_length_q  <= key_length_d;
    end
  end

  assign cfg_o.key_letters = key_letters_q;
  assign cfg_o.key_length  = key_length_q;

endmodule

// ===== rtl/akc_front.sv =====
module akc_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [akc_pkg::ByteW-1:0] in_byte_i,
  input  logic                      in_start_i,
  output logic                      q_valid_o,
  input  logic                      q_pop_i,
  output akc_pkg::akc_item_t        q_item_o
);

  akc_pkg::akc_item_t             entry_q [akc_pkg::QueueDepth];
  akc_pkg::akc_item_t             item;
  logic [akc_pkg::QPtrW-1:0]      wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [akc_pkg::QCntW-1:0]      count_q, count_d;
  logic                           push, pop;

  // Classify the byte as it comes in, so the back only looks at one flag.
  always_comb begin
    item.data      = in_byte_i;
    item.is_letter = (in_byte_i >= akc_pkg::CharA) && (in_byte_i <= akc_pkg::CharZ);
    item.start     = in_start_i;
  end

  assign in_ready_o = (count_q != akc_pkg::QCntW'(akc_pkg::QueueDepth));
  assign q_valid_o  = (count_q != '0);
  assign q_item_o   = entry_q[rd_ptr_q];
  assign push       = in_valid_i & in_ready_o;
  assign pop        = q_pop_i & q_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == akc_pkg::QPtrW'(akc_pkg::QueueDepth - 1)) ? '0
                                                                        : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == akc_pkg::QPtrW'(akc_pkg::QueueDepth - 1)) ? '0
                                                                        : rd_ptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== rtl/akc_back.sv =====
module akc_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  akc_pkg::akc_cfg_t         cfg_i,
  input  logic                      q_valid_i,
  output logic                      q_pop_o,
  input  akc_pkg::akc_item_t        q_item_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [akc_pkg::ByteW-1:0] out_byte_o,
  output logic                      out_letter_o
);

  logic [akc_pkg::SlotW-1:0] ring_q [akc_pkg::KeyMax];
  logic [akc_pkg::PosW-1:0]  pos_q, pos_d;
  logic                      primed_q;
  logic                      out_valid_q, out_valid_d;
  logic [akc_pkg::ByteW-1:0] out_byte_q, out_byte_d;
  logic                      out_letter_q;

  logic                      fire, reload;
  logic [akc_pkg::LenW-1:0]  len;
  logic [akc_pkg::PosW-1:0]  pos_raw, pos_eff, pos_inc;
  logic [akc_pkg::SlotW-1:0] p, k;
  logic [akc_pkg::SlotW:0]   sum, sum1, sum2;

  assign fire    = q_valid_i & (~out_valid_q | out_ready_i);
  assign q_pop_o = fire;

  // A zero length counts as one, anything beyond the ring as the full ring.
  always_comb begin
    if (cfg_i.key_length == '0) begin
      len = akc_pkg::LenW'(1);
    end else if (cfg_i.key_length > akc_pkg::LenW'(akc_pkg::KeyMax)) begin
      len = akc_pkg::LenW'(akc_pkg::KeyMax);
    end else begin
      len = cfg_i.key_length;
    end
  end

  always_comb begin
    reload  = q_item_i.start | ~primed_q;
    pos_raw = reload ? '0 : pos_q;
    pos_eff = (akc_pkg::LenW'(pos_raw) >= len) ? '0 : pos_raw;
    pos_inc = pos_eff + 1'b1;
    p       = akc_pkg::SlotW'(q_item_i.data - akc_pkg::CharA);
    k       = reload ? cfg_i.key_letters[akc_pkg::SlotW-1:0] : ring_q[pos_eff];
    // For a letter the sum is at most 56, so two conditional subtractions reduce it mod 26.
    sum     = {1'b0, p} + {1'b0, k};
    sum1    = (sum >= akc_pkg::Modulus) ? sum - akc_pkg::Modulus : sum;
    sum2    = (sum1 >= akc_pkg::Modulus) ? sum1 - akc_pkg::Modulus : sum1;
  end

  always_comb begin
    out_byte_d = q_item_i.is_letter ? akc_pkg::CharA + akc_pkg::ByteW'(sum2)
                                    : q_item_i.data;
    if (!q_item_i.is_letter) begin
      pos_d = pos_eff;
    end else if (akc_pkg::LenW'(pos_inc) == len) begin
      pos_d = '0;
    end else begin
      pos_d = pos_inc;
    end
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // The plaintext letter takes the place of the key letter it used.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      for (int unsigned i = 0; i < akc_pkg::KeyMax; i++) begin
        if (q_item_i.is_letter && (pos_eff == akc_pkg::PosW'(i))) begin
          ring_q[i] <= p;
        end else if (reload) begin
          ring_q[i] <= cfg_i.key_letters[akc_pkg::SlotW*i +: akc_pkg::SlotW];
        end
      end
      out_byte_q   <= out_byte_d;
      out_letter_q <= q_item_i.is_letter;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      primed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (fire) begin
        pos_q    <= pos_d;
        primed_q <= 1'b1;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign out_letter_o = out_letter_q;

endmodule

// ===== rtl/autokey_cipher_encrypt_top.sv =====
// Autokey cipher encryptor. One byte is taken per clock cycle while the output is not
// stalled, one result per byte, via a two-entry queue after the classifying front and the
// output register; a full queue drops s_axis_tready. Uppercase letters are enciphered with
// the current keystream letter and then replace it in the key ring; every other byte passes
// unchanged with tuser low. A request with tuser set, or the first one after reset, reloads
// the ring from the key register. The key and its length are to be written by the user
// over the APB port only while no request is in flight; the block does not enforce this.
module autokey_cipher_encrypt_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [akc_pkg::AddrW-1:0] paddr,
  input  logic [akc_pkg::DataW-1:0] pwdata,
  output logic [akc_pkg::DataW-1:0] prdata,
  output logic                      pready,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,   // [7:0] plain_byte
  input  logic                      s_axis_tuser,   // [0] start_of_message
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [7:0]                m_axis_tdata,   // [7:0] cipher_byte
  output logic                      m_axis_tuser    // [0] was_letter
);

  akc_pkg::akc_cfg_t  cfg;
  akc_pkg::akc_item_t q_item;
  logic               q_valid, q_pop;

  akc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  akc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .in_start_i (s_axis_tuser),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_item_o   (q_item)
  );

  akc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .q_valid_i    (q_valid),
    .q_pop_o      (q_pop),
    .q_item_i     (q_item),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (m_axis_tdata),
    .out_letter_o (m_axis_tuser)
  );

`ifndef SYNTHESIS
  // An enciphered byte is always an uppercase letter.
  a_letter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |->
      (m_axis_tdata >= akc_pkg::CharA && m_axis_tdata <= akc_pkg::CharZ))
    else $error("enciphered byte outside A to Z");

  // A byte passed through unchanged can never be an uppercase letter.
  a_passthrough: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |->
      (m_axis_tdata < akc_pkg::CharA || m_axis_tdata > akc_pkg::CharZ))
    else $error("uppercase letter passed through without enciphering");

  // The queue is drained whenever the output register can take a result.
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid && !m_axis_tvalid) |-> q_pop)
    else $error("queued request held while output register empty");
`endif

endmodule

// ===== dv/akc_cipher_checker.sv =====
module akc_cipher_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic                      pready,
  input  logic [akc_pkg::AddrW-1:0] paddr,
  input  logic [akc_pkg::DataW-1:0] pwdata,
  input  logic                      s_axis_tvalid,
  input  logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,   // [7:0] plain_byte
  input  logic                      s_axis_tuser,   // [0] start_of_message
  input  logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  input  logic [7:0]                m_axis_tdata,   // [7:0] cipher_byte
  input  logic                      m_axis_tuser,   // [0] was_letter
  output int                        pending_o,
  output int                        fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [akc_pkg::ByteW-1:0] cipher_byte;
    logic                      was_letter;
  } cipher_result_t;

  logic [akc_pkg::KeyW-1:0]  key_letters_q;
  logic [akc_pkg::LenW-1:0]  key_length_q;
  logic [akc_pkg::SlotW-1:0] key_ring [akc_pkg::KeyMax];
  logic [akc_pkg::LenW-1:0]  ring_pos;
  logic                      primed;
  cipher_result_t            expected_cipher_q [$];

  task automatic note_mismatch(input string msg);
    fail_count_o++;
    if (fail_count_o <= 10) begin
      $display("checker: %s", msg);
    end
  endtask

  // Works out the cipher result of one request and advances the keystream ring.
  task automatic encipher_byte(input logic [akc_pkg::ByteW-1:0] plain, input logic restart,
                               output cipher_result_t res);
    logic [akc_pkg::LenW-1:0]  span;
    logic [akc_pkg::SlotW-1:0] p;
    logic [akc_pkg::SlotW:0]   total;
    if (restart || !primed) begin
      for (int i = 0; i < akc_pkg::KeyMax; i++) begin
        key_ring[i] = key_letters_q[akc_pkg::SlotW*i +: akc_pkg::SlotW];
      end
      ring_pos = '0;
      primed   = 1'b1;
    end
    // A length of zero behaves as one, anything above the ring size as the ring size.
    span = key_length_q;
    if (span == '0) begin
      span = akc_pkg::LenW'(1);
    end
    if (span > akc_pkg::KeyMax) begin
      span = akc_pkg::LenW'(akc_pkg::KeyMax);
    end
    if (ring_pos >= span) begin
      ring_pos = '0;
    end
    if (plain >= akc_pkg::CharA && plain <= akc_pkg::CharZ) begin
      p     = akc_pkg::SlotW'(plain - akc_pkg::CharA);
      total = {1'b0, p} + {1'b0, key_ring[ring_pos]};
      res.cipher_byte = akc_pkg::CharA + akc_pkg::ByteW'(total % akc_pkg::Modulus);
      res.was_letter  = 1'b1;
      key_ring[ring_pos] = p;
      ring_pos = akc_pkg::LenW'((ring_pos + akc_pkg::LenW'(1)) % span);
    end else begin
      res.cipher_byte = plain;
      res.was_letter  = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cipher_result_t want;
    cipher_result_t got;
    if (!rst_ni) begin
      key_letters_q = '0;
      key_length_q  = akc_pkg::KeyLenReset;
      ring_pos      = '0;
      primed        = 1'b0;
      expected_cipher_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[3] == akc_pkg::RegKeyLength) begin
          key_length_q = pwdata[akc_pkg::LenW-1:0];
        end else begin
          key_letters_q = pwdata[akc_pkg::KeyW-1:0];
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        encipher_byte(s_axis_tdata, s_axis_tuser, want);
        expected_cipher_q.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.cipher_byte = m_axis_tdata;
        got.was_letter  = m_axis_tuser;
        if (expected_cipher_q.size() == 0) begin
          note_mismatch($sformatf("result %h/%b with no request outstanding",
                                  got.cipher_byte, got.was_letter));
        end else begin
          want = expected_cipher_q.pop_front();
          if (got.cipher_byte !== want.cipher_byte) begin
            note_mismatch($sformatf("cipher_byte expected %h got %h",
                                    want.cipher_byte, got.cipher_byte));
          end
          if (got.was_letter !== want.was_letter) begin
            note_mismatch($sformatf("was_letter expected %b got %b for byte %h",
                                    want.was_letter, got.was_letter, want.cipher_byte));
          end
        end
      end
    end
    pending_o = expected_cipher_q.size();
  end

endmodule

// ===== dv/tb_autokey_cipher_encrypt_top.sv =====
module tb_autokey_cipher_encrypt_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned PhaseItems    = 216;
  localparam int unsigned NumPhases     = 8;
  localparam int unsigned HoldOffCycles = 300;
  localparam logic [akc_pkg::AddrW-1:0] AddrKeyLetters = {akc_pkg::RegKeyLetters, 3'b000};
  localparam logic [akc_pkg::AddrW-1:0] AddrKeyLength  = {akc_pkg::RegKeyLength, 3'b000};
  localparam logic [akc_pkg::ByteW-1:0] SpaceChar  = 8'h20;
  localparam logic [akc_pkg::ByteW-1:0] LowerCharA = 8'h61;

  logic                      clk_i;
  logic                      rst_ni  = 1'b0;
  logic                      psel    = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite  = 1'b0;
  logic [akc_pkg::AddrW-1:0] paddr   = '0;
  logic [akc_pkg::DataW-1:0] pwdata  = '0;
  logic [akc_pkg::DataW-1:0] prdata;
  logic                      pready;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [7:0]                s_axis_tdata  = '0;   // [7:0] plain_byte
  logic                      s_axis_tuser  = 1'b0; // [0] start_of_message
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [7:0]                m_axis_tdata;         // [7:0] cipher_byte
  logic                      m_axis_tuser;         // [0] was_letter

  int idle_pct     = 0;
  int stall_pct    = 0;
  int hold_request = 0;
  int hold_taken   = 0;
  int hold_left    = 0;
  int quiet_cycles = 0;
  int items_sent   = 0;
  int letters_sent = 0;
  int starts_sent  = 0;
  int key_settings = 0;
  int pending;
  int fail_count;

  autokey_cipher_encrypt_top dut (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser
  );

  akc_cipher_checker u_checker (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .pready,
    .paddr,
    .pwdata,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Output side: random stalls, with one long hold-off that backs the block up.
  always @(posedge clk_i) begin
    if (hold_left == 0 && hold_request != hold_taken) begin
      hold_left  = HoldOffCycles;
      hold_taken = hold_request;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (psel && penable)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WatchdogLimit) begin
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  function automatic logic [akc_pkg::ByteW-1:0] random_plain();
    int pick = $urandom_range(99);
    if (pick < 65) begin
      return akc_pkg::CharA + akc_pkg::ByteW'($urandom_range(25));
    end else if (pick < 78) begin
      return SpaceChar;
    end else if (pick < 85) begin
      return LowerCharA + akc_pkg::ByteW'($urandom_range(25));
    end
    return akc_pkg::ByteW'($urandom_range(255));
  endfunction

  function automatic logic [akc_pkg::KeyW-1:0] random_key(input int unsigned slot_max);
    logic [akc_pkg::KeyW-1:0] key = '0;
    for (int i = 0; i < akc_pkg::KeyMax; i++) begin
      key[akc_pkg::SlotW*i +: akc_pkg::SlotW] = akc_pkg::SlotW'($urandom_range(slot_max));
    end
    return key;
  endfunction

  task automatic send_request(input logic [akc_pkg::ByteW-1:0] plain, input logic restart);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= plain;
    s_axis_tuser  <= restart;
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    items_sent++;
    if (plain >= akc_pkg::CharA && plain <= akc_pkg::CharZ) begin
      letters_sent++;
    end
    if (restart) begin
      starts_sent++;
    end
  endtask

  task automatic send_text(input string text, input logic restart_first);
    for (int i = 0; i < text.len(); i++) begin
      send_request(text[i], (i == 0) ? restart_first : 1'b0);
    end
  endtask

  // Every request gives exactly one result, so an empty scoreboard means the block is idle.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [akc_pkg::AddrW-1:0] addr,
                                input logic [akc_pkg::DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (!pready);
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [akc_pkg::KeyW-1:0] key_dir;
    int                       first_restart;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset key: the first request must load the ring even without a start flag.
    send_text("AZ az@[", 1'b0);
    send_request(8'h00, 1'b0);
    send_request(8'hFF, 1'b0);
    send_request(8'h80, 1'b1);
    wait_idle();

    // Short key with a letter of 25 and a slot value above 25.
    key_dir = '0;
    key_dir[akc_pkg::SlotW*0 +: akc_pkg::SlotW] = akc_pkg::SlotW'(25);
    key_dir[akc_pkg::SlotW*2 +: akc_pkg::SlotW] = akc_pkg::SlotW'(31);
    write_register(AddrKeyLetters, akc_pkg::DataW'(key_dir));
    write_register(AddrKeyLength, akc_pkg::DataW'(3));
    key_settings++;
    send_text("AZM QBYZ", 1'b1);
    wait_idle();

    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: begin
          key_dir = '0;
          for (int i = 0; i < akc_pkg::KeyMax; i++) begin
            key_dir[akc_pkg::SlotW*i +: akc_pkg::SlotW] = akc_pkg::SlotW'(25);
          end
          write_register(AddrKeyLetters, akc_pkg::DataW'(key_dir));
          write_register(AddrKeyLength, akc_pkg::DataW'(akc_pkg::KeyMax));
        end
        1: begin
          write_register(AddrKeyLetters, akc_pkg::DataW'({akc_pkg::KeyW{1'b1}}));
          write_register(AddrKeyLength, akc_pkg::DataW'(15));
        end
        2: begin
          write_register(AddrKeyLetters, akc_pkg::DataW'(random_key(25)));
          write_register(AddrKeyLength, akc_pkg::DataW'(0));
        end
        3: begin
          write_register(AddrKeyLetters, '0);
          write_register(AddrKeyLength, akc_pkg::DataW'(13));
        end
        4: begin
          write_register(AddrKeyLetters, akc_pkg::DataW'(random_key(31)));
          write_register(AddrKeyLength, akc_pkg::DataW'($urandom_range(akc_pkg::KeyMax, 1)));
        end
        // Length only: a shorter ring takes effect on the running message.
        5: write_register(AddrKeyLength, akc_pkg::DataW'(3));
        6: begin
          write_register(AddrKeyLetters, akc_pkg::DataW'(random_key(25)));
          write_register(AddrKeyLength, akc_pkg::DataW'(1));
        end
        default: begin
          write_register(AddrKeyLetters, akc_pkg::DataW'(random_key(31)));
          write_register(AddrKeyLength, akc_pkg::DataW'($urandom_range(akc_pkg::KeyMax, 2)));
        end
      endcase
      key_settings++;

      case (phase % 4)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 87;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 87;
        end
        default: begin
          idle_pct  = 13;
          stall_pct = 13;
        end
      endcase

      // Each phase by chance restarts or carries on the message from before the write.
      first_restart = $urandom_range(1);
      for (int n = 0; n < PhaseItems; n++) begin
        if (phase == 0 && n == 20) begin
          hold_request++;
        end
        send_request(random_plain(),
                     (n == 0) ? 1'(first_restart) : ($urandom_range(24) == 0));
      end
      wait_idle();
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    $display("tb: %0d requests sent, %0d letters, %0d with a restart, over %0d key settings",
             items_sent, letters_sent, starts_sent, key_settings);
    $display("tb: idling on neither, either and both sides, plus one %0d-cycle output hold-off",
             HoldOffCycles);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
